// ----- rtl/tli_pkg.sv -----
// Shared types and constants for the table linear interpolator.
// Used by tli_cell, tli_div and table_linear_interpolator_top.
`default_nettype none
package tli_pkg;

  localparam int DEPTH = 256;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int PROD_W = 2 * VAL_W;
  localparam int DCNT_W = $clog2(PROD_W + 1);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [VAL_W-1:0] mag_t;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_SAT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SEL,
    S_READ,
    S_DEC,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_SUM,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/tli_cell.sv -----
// One breakpoint cell of the sorted table: holds an (x, y) pair.
// Depends on tli_pkg; shifts its pair to the right neighbor on insertion.
`default_nettype none
module tli_cell import tli_pkg::*; (
  input  wire  clk,
  input  wire  wr_en,
  input  val_t key,
  input  val_t new_y,
  input  wire  valid,
  input  wire  slot_free,
  input  wire  left_shift,
  input  val_t left_x,
  input  val_t left_y,
  output val_t cell_x,
  output val_t cell_y,
  output logic gt,
  output logic ge
);

  val_t x_r, x_nxt;
  val_t y_r, y_nxt;

  assign gt = valid && (x_r > key);
  assign ge = valid && (x_r >= key);
  assign cell_x = x_r;
  assign cell_y = y_r;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (wr_en) begin
      if (left_shift) begin
        x_nxt = left_x;
        y_nxt = left_y;
      end else if (gt || slot_free) begin
        x_nxt = key;
        y_nxt = new_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/tli_div.sv -----
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit unsigned.
// Depends on tli_pkg for widths.
`default_nettype none
module tli_div import tli_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire  [PROD_W-1:0]  dividend,
  input  mag_t               divisor,
  output logic [PROD_W-1:0]  quotient,
  output logic               done
);

  logic [PROD_W-1:0] dvd_r, quo_r;
  mag_t              rem_r, dsr_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              run_r, done_r;
  logic [VAL_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, dvd_r[PROD_W-1]};
  assign fits = trial >= {1'b0, dsr_r};
  assign quotient = quo_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[PROD_W-2:0], 1'b0};
      rem_r <= fits ? VAL_W'(trial - {1'b0, dsr_r}) : trial[VAL_W-1:0];
      quo_r <= {quo_r[PROD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DCNT_W'(PROD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !run_r)
    else $error("divider done while still running");
  assert property (@(posedge clk) disable iff (!rst_n) run_r |-> cnt_r != '0)
    else $error("divider running with empty count");
  assert property (@(posedge clk) disable iff (!rst_n) $fell(run_r) |-> done_r)
    else $error("divider stopped without done");

endmodule
`default_nettype wire

// ----- rtl/table_linear_interpolator_top.sv -----
// Top level of the table linear interpolator: a row of 256 breakpoint cells,
// a control sequencer and a shared divider. Depends on tli_pkg, tli_cell, tli_div.
//
// Usage: drive in_cmd, in_x_value and in_y_in with start high; the transfer
// happens at a clock edge where busy is low. Commands are clear, insert and
// query. Each command gives exactly one result on out_y_out, out_status and
// out_out_of_range, valid for the single cycle in which out_strobe is high.
// The receiver cannot stall, so the result must be taken in that cycle.
// Clear, insert and unused commands, and a query on an empty table, go from
// the execute state straight to the output state, after which busy falls. A
// query that hits a point or clamps passes through the select, read and decide
// states first; one that interpolates or extrapolates also passes through the
// multiply, divider start, bit-serial divide and sum states.
// Insertion shifts all larger points one cell to the right at once, in the execute state.
// The mode register cfg_extrapolate_mode is written with cfg_we; the user must
// do so only while idle, as the block itself does not enforce it. Reset empties
// the table and clears the mode to clamping; no clearing pass is needed.
`default_nettype none
module table_linear_interpolator_top import tli_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire  [1:0] in_cmd,
  input  val_t       in_x_value,
  input  val_t       in_y_in,
  output logic       out_strobe,
  output val_t       out_y_out,
  output logic [1:0] out_status,
  output logic       out_out_of_range,
  input  wire        cfg_we,
  input  wire        cfg_extrapolate_mode
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic mode_r;

  logic [1:0] cmd_r;
  val_t key_r, yin_r;
  val_t res_r;
  logic [1:0] status_r;
  logic oor_r;

  logic [DEPTH-1:0] valid, slot_free, gt, ge, ge_r, gt_r;
  logic [DEPTH-1:0] last_sel, hit, sel_up, sel_up_r;
  val_t cell_x [DEPTH];
  val_t cell_y [DEPTH];
  logic below_r, above_r, below, above, multi, full;
  val_t x1_r, y1_r, x2_r, y2_r;
  val_t rx1, ry1, rx2, ry2;
  logic cell_wr, div_start, div_done;
  logic [PROD_W-1:0] prod_r, div_quo;
  mag_t dq_mag_r, dy_mag_r, dx_mag_r;
  logic neg_r;
  logic signed [VAL_W:0] dq, dy, dx;
  logic dec_direct;
  val_t dec_res;
  logic signed [VAL_W+2:0] sum;
  logic quo_big;

  function automatic mag_t abs33(input logic signed [VAL_W:0] d);
    logic signed [VAL_W:0] n;
    n = -d;
    return d[VAL_W] ? n[VAL_W-1:0] : d[VAL_W-1:0];
  endfunction

  assign multi = count_r > CNT_W'(1);
  assign full = count_r >= CNT_W'(DEPTH);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid[i] = count_r > CNT_W'(i);
    assign slot_free[i] = count_r == CNT_W'(i);
    if (i == 0) begin : g_first
      tli_cell u_cell (
        .clk(clk), .wr_en(cell_wr), .key(key_r), .new_y(yin_r),
        .valid(valid[i]), .slot_free(slot_free[i]), .left_shift(1'b0),
        .left_x(key_r), .left_y(yin_r), .cell_x(cell_x[i]), .cell_y(cell_y[i]),
        .gt(gt[i]), .ge(ge[i])
      );
      assign hit[i] = ge_r[i];
    end else begin : g_next
      tli_cell u_cell (
        .clk(clk), .wr_en(cell_wr), .key(key_r), .new_y(yin_r),
        .valid(valid[i]), .slot_free(slot_free[i]), .left_shift(gt[i-1]),
        .left_x(cell_x[i-1]), .left_y(cell_y[i-1]), .cell_x(cell_x[i]),
        .cell_y(cell_y[i]), .gt(gt[i]), .ge(ge[i])
      );
      assign hit[i] = ge_r[i] & ~ge_r[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign last_sel[i] = valid[i];
    end else begin : g_mid
      assign last_sel[i] = valid[i] & ~valid[i+1];
    end
  end

  assign below = gt_r[0];
  assign above = ~|ge_r;

  always_comb begin
    sel_up = hit;
    if (below) begin
      sel_up = '0;
      sel_up[0] = !multi;
      sel_up[1] = multi;
    end else if (above) begin
      sel_up = last_sel;
    end
  end

  always_comb begin
    rx1 = '0;
    ry1 = '0;
    rx2 = '0;
    ry2 = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel_up_r[i]) begin
        rx2 = rx2 | cell_x[i];
        ry2 = ry2 | cell_y[i];
      end
      if (i < DEPTH - 1 && sel_up_r[(i + 1) % DEPTH]) begin
        rx1 = rx1 | cell_x[i];
        ry1 = ry1 | cell_y[i];
      end
    end
  end

  assign dx = {x2_r[VAL_W-1], x2_r} - {x1_r[VAL_W-1], x1_r};
  assign dq = {key_r[VAL_W-1], key_r} - {x1_r[VAL_W-1], x1_r};
  assign dy = {y2_r[VAL_W-1], y2_r} - {y1_r[VAL_W-1], y1_r};

  always_comb begin
    dec_direct = 1'b0;
    dec_res = y1_r;
    if (below_r && (!mode_r || !multi)) begin
      dec_direct = 1'b1;
      dec_res = multi ? y1_r : y2_r;
    end else if (above_r && (!mode_r || !multi)) begin
      dec_direct = 1'b1;
      dec_res = y2_r;
    end else if (!below_r && !above_r && x2_r == key_r) begin
      dec_direct = 1'b1;
      dec_res = y2_r;
    end else if (dx == '0) begin
      dec_direct = 1'b1;
      dec_res = y1_r;
    end
  end

  assign quo_big = |div_quo[PROD_W-1:VAL_W+1];
  assign sum = {{3{y1_r[VAL_W-1]}}, y1_r}
             + (neg_r ? -{2'b00, div_quo[VAL_W:0]} : {2'b00, div_quo[VAL_W:0]});

  tli_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(prod_r),
    .divisor(dx_mag_r), .quotient(div_quo), .done(div_done)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = (cmd_r == CMD_QUERY && count_r != '0) ? S_SEL : S_OUT;
      S_SEL:    state_nxt = S_READ;
      S_READ:   state_nxt = S_DEC;
      S_DEC:    state_nxt = dec_direct ? S_OUT : S_MUL;
      S_MUL:    state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DIV;
      S_DIV:    if (div_done) state_nxt = S_SUM;
      S_SUM:    state_nxt = S_OUT;
      S_OUT:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy = state_r != S_IDLE;
    out_strobe = state_r == S_OUT;
    cell_wr = state_r == S_EXEC && cmd_r == CMD_INSERT && !full;
    div_start = state_r == S_DSTART;
  end

  assign out_y_out = res_r;
  assign out_status = status_r;
  assign out_out_of_range = oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      mode_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) mode_r <= cfg_extrapolate_mode;
      if (state_r == S_EXEC) begin
        if (cmd_r == CMD_CLEAR) count_r <= '0;
        else if (cell_wr) count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cmd_r <= in_cmd;
        key_r <= in_x_value;
        yin_r <= in_y_in;
      end
      S_EXEC: begin
        res_r <= '0;
        oor_r <= 1'b0;
        status_r <= ST_OK;
        if (cmd_r == CMD_INSERT && full) status_r <= ST_FULL;
        if (cmd_r == CMD_QUERY && count_r == '0) status_r <= ST_EMPTY;
        ge_r <= ge;
        gt_r <= gt;
      end
      S_SEL: begin
        sel_up_r <= sel_up;
        below_r <= below;
        above_r <= above;
      end
      S_READ: begin
        x1_r <= rx1;
        y1_r <= ry1;
        x2_r <= rx2;
        y2_r <= ry2;
      end
      S_DEC: begin
        oor_r <= below_r | above_r;
        res_r <= dec_res;
        dq_mag_r <= abs33(dq);
        dy_mag_r <= abs33(dy);
        dx_mag_r <= abs33(dx);
        neg_r <= dq[VAL_W] ^ dy[VAL_W] ^ dx[VAL_W];
      end
      S_MUL: prod_r <= PROD_W'(dq_mag_r * dy_mag_r);
      S_SUM: begin
        if (quo_big) begin
          status_r <= ST_SAT;
          res_r <= neg_r ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else if (sum > $signed({4'b0000, {(VAL_W-1){1'b1}}})) begin
          status_r <= ST_SAT;
          res_r <= {1'b0, {(VAL_W-1){1'b1}}};
        end else if (sum < $signed({3'b111, 1'b1, {(VAL_W-1){1'b0}}})) begin
          status_r <= ST_SAT;
          res_r <= {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
          res_r <= sum[VAL_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_strobe |-> busy)
    else $error("result shown while idle");
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(DEPTH))
    else $error("point count beyond table depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> $onehot(sel_up_r))
    else $error("segment selection not one-hot");
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer accepted but block not busy");

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for table_linear_interpolator_top: directed table plus random
// clear/insert/query/unused traffic, checked against an in-bench table predictor.
// Depends on rtl/tli_pkg.sv and rtl/table_linear_interpolator_top.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tli_pkg::*;

  typedef struct packed {
    val_t       y;
    logic [1:0] st;
    logic       oor;
  } interp_result_t;

  typedef struct {
    logic [1:0]     cmd;
    val_t           xv;
    val_t           yv;
    logic           known;
    interp_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_cmd = CMD_CLEAR;
  val_t in_x_value = '0;
  val_t in_y_in = '0;
  logic out_strobe;
  val_t out_y_out;
  logic [1:0] out_status;
  logic out_out_of_range;
  logic cfg_we = 1'b0;
  logic cfg_extrapolate_mode = 1'b0;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  table_linear_interpolator_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_x_value(in_x_value), .in_y_in(in_y_in),
    .out_strobe(out_strobe), .out_y_out(out_y_out), .out_status(out_status),
    .out_out_of_range(out_out_of_range),
    .cfg_we(cfg_we), .cfg_extrapolate_mode(cfg_extrapolate_mode)
  );

  always #2 clk = ~clk;

  longint bp_x[DEPTH];
  longint bp_y[DEPTH];
  int bp_count = 0;
  bit mode_extend = 1'b0;
  interp_result_t pending_results[$];
  int fail_count = 0;
  longint cycle_count = 0;
  bit quiet_sender = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  function automatic longint segment_value(input longint q, input longint x1, input longint y1,
                                           input longint x2, input longint y2, inout bit sat);
    longint dq, dy, dx, r;
    logic signed [127:0] prod, quo;
    dq = q - x1;
    dy = y2 - y1;
    dx = x2 - x1;
    if (dx == 0 || dq == 0 || dy == 0) return y1;
    prod = 128'(dq) * 128'(dy);
    quo = prod / 128'(dx);
    if (quo > 128'(VMAX) * 4 || quo < -(128'(VMAX) * 4)) begin
      sat = 1'b1;
      return quo < 0 ? VMIN : VMAX;
    end
    r = y1 + longint'(quo);
    if (r > VMAX) begin
      sat = 1'b1;
      return VMAX;
    end
    if (r < VMIN) begin
      sat = 1'b1;
      return VMIN;
    end
    return r;
  endfunction

  function automatic interp_result_t table_step(input logic [1:0] cmd, input val_t xs,
                                                input val_t ys);
    interp_result_t r;
    longint q, res;
    int pos, lo, hi, mid, last;
    bit sat;
    r = '0;
    q = xs;
    res = 0;
    sat = 1'b0;
    if (cmd == CMD_CLEAR) begin
      bp_count = 0;
    end else if (cmd == CMD_INSERT) begin
      if (bp_count >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        pos = bp_count;
        while (pos > 0 && bp_x[pos-1] > q) begin
          bp_x[pos] = bp_x[pos-1];
          bp_y[pos] = bp_y[pos-1];
          pos--;
        end
        bp_x[pos] = q;
        bp_y[pos] = ys;
        bp_count++;
      end
    end else if (cmd == CMD_QUERY) begin
      if (bp_count == 0) begin
        r.st = ST_EMPTY;
      end else begin
        last = bp_count - 1;
        if (q < bp_x[0] || q > bp_x[last]) begin
          r.oor = 1'b1;
          if (!mode_extend || bp_count == 1) res = q < bp_x[0] ? bp_y[0] : bp_y[last];
          else if (q < bp_x[0])
            res = segment_value(q, bp_x[0], bp_y[0], bp_x[1], bp_y[1], sat);
          else
            res = segment_value(q, bp_x[last-1], bp_y[last-1], bp_x[last], bp_y[last], sat);
        end else begin
          lo = 0;
          hi = last;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (bp_x[mid] < q) lo = mid + 1;
            else hi = mid;
          end
          if (bp_x[lo] == q) begin
            res = bp_y[lo];
          end else begin
            if (lo == 0) lo = 1;
            res = segment_value(q, bp_x[lo-1], bp_y[lo-1], bp_x[lo], bp_y[lo], sat);
          end
        end
        if (sat) r.st = ST_SAT;
      end
      r.y = val_t'(res);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    interp_result_t w;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_y_out, 0);
      end else begin
        w = pending_results.pop_front();
        if (out_y_out !== w.y) report_mismatch("y_out", out_y_out, w.y);
        if (out_status !== w.st) report_mismatch("status", out_status, w.st);
        if (out_out_of_range !== w.oor)
          report_mismatch("out_of_range", out_out_of_range, w.oor);
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input val_t xs, input val_t ys,
                           input bit known, input interp_result_t want);
    interp_result_t p;
    int gap;
    if (!quiet_sender && $urandom_range(3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_x_value <= xs;
    in_y_in <= ys;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = table_step(cmd, xs, ys);
    if (known && p !== want) report_mismatch("directed row", p.y, want.y);
    pending_results.push_back(known ? want : p);
  endtask

  task automatic drain_and_set_mode(input bit m);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_extrapolate_mode <= m;
    mode_extend = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic val_t rand_x();
    case ($urandom_range(5))
      0: return val_t'($urandom());
      1: return $urandom_range(1) ? val_t'(VMAX) : val_t'(VMIN);
      default: return val_t'($signed($urandom_range(4000)) - 2000) <<< $urandom_range(16);
    endcase
  endfunction

  stim_row_t dir_rows[$];
  interp_result_t z;

  function automatic stim_row_t row(input logic [1:0] c, input val_t xs, input val_t ys,
                                    input bit k, input val_t y, input logic [1:0] s,
                                    input logic o);
    stim_row_t r;
    r.cmd = c;
    r.xv = xs;
    r.yv = ys;
    r.known = k;
    r.want = '{y: y, st: s, oor: o};
    return r;
  endfunction

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    dir_rows = '{
      row(CMD_QUERY, 0, 0, 1, 0, ST_EMPTY, 0),
      row(CMD_UNUSED, -1, -1, 1, 0, ST_OK, 0),
      row(CMD_INSERT, 100, -1, 1, 0, ST_OK, 0),
      row(CMD_QUERY, 100, 0, 1, -1, ST_OK, 0),
      row(CMD_QUERY, val_t'(VMIN), 0, 1, -1, ST_OK, 1),
      row(CMD_INSERT, 100, 500, 1, 0, ST_OK, 0),
      row(CMD_QUERY, 100, 0, 0, 0, ST_OK, 0),
      row(CMD_INSERT, val_t'(VMAX), val_t'(VMAX), 1, 0, ST_OK, 0),
      row(CMD_INSERT, val_t'(VMIN), val_t'(VMIN), 1, 0, ST_OK, 0),
      row(CMD_QUERY, 0, 0, 0, 0, ST_OK, 0),
      row(CMD_QUERY, 5000, 0, 0, 0, ST_OK, 0),
      row(CMD_QUERY, val_t'(VMAX), 0, 1, val_t'(VMAX), ST_OK, 0),
      row(CMD_CLEAR, 0, 0, 1, 0, ST_OK, 0),
      row(CMD_QUERY, 7, 0, 1, 0, ST_EMPTY, 0)
    };
    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].xv, dir_rows[i].yv, dir_rows[i].known,
                dir_rows[i].want);
    drain_and_set_mode(1'b1);
    z = '0;
    send_item(CMD_INSERT, 0, 0, 0, z);
    send_item(CMD_INSERT, 1, val_t'(VMAX), 0, z);
    send_item(CMD_QUERY, 1000, 0, 0, z);
    send_item(CMD_QUERY, -1000, 0, 0, z);
    send_item(CMD_INSERT, 1, 5, 0, z);
    send_item(CMD_QUERY, 2, 0, 0, z);
    send_item(CMD_CLEAR, 0, 0, 0, z);
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(CMD_INSERT, rand_x(), val_t'($urandom()), 0, z);
    send_item(CMD_QUERY, rand_x(), 0, 0, z);
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_set_mode(ph[0]);
      send_item(CMD_CLEAR, 0, 0, 0, z);
      n = $urandom_range(2, 12);
      for (int i = 0; i < 195; i++) begin
        quiet_sender = (ph == 5);
        if (i % 60 == 59) begin
          send_item(CMD_CLEAR, 0, 0, 0, z);
          n = $urandom_range(1, 12);
        end else if (n > 0) begin
          send_item(CMD_INSERT, rand_x(), val_t'($urandom()), 0, z);
          n--;
        end else if ($urandom_range(19) == 0) begin
          send_item(CMD_UNUSED, val_t'($urandom()), val_t'($urandom()), 0, z);
        end else begin
          send_item(CMD_QUERY,
                    $urandom_range(1) ? rand_x() : val_t'(bp_x[$urandom_range(bp_count-1)]),
                    val_t'($urandom()), 0, z);
        end
      end
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
